@@ rtl/multi_key_substring_matcher_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the multi-key substring matcher.
// ----------------------------------------------------------------------------
`ifndef MULTI_KEY_SUBSTRING_MATCHER_DEFINES_SVH
`define MULTI_KEY_SUBSTRING_MATCHER_DEFINES_SVH
// Checks that the consequent holds whenever the antecedent holds.
`define MKSM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define MKSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

@@ rtl/mksm_pkg.sv @@
// ----------------------------------------------------------------------------
// mksm_pkg
// Shared constants and types of the multi-key substring matcher.
// ----------------------------------------------------------------------------
package mksm_pkg;
   localparam int NUM_KEYS    = 64;
   localparam int MAX_KEY_LEN = 65;
   localparam int CNT_W       = $clog2(NUM_KEYS + 1);
   localparam int LEN_W       = $clog2(MAX_KEY_LEN + 2);
   localparam int SLOT_W      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int POS_W       = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_SCAN = 1'b1;

   typedef enum logic [2:0] {
      RC_STORED   = 3'd0,
      RC_TOO_LONG = 3'd1,
      RC_FULL     = 3'd2,
      RC_NO_MATCH = 3'd3,
      RC_MATCHED  = 3'd4
   } result_code_type;

   // Control word broadcast along the row of key cells.
   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_slot;
      logic [POS_W-1:0]  wr_pos;
      logic [7:0]        wr_byte;
      logic              commit;
      logic [LEN_W-1:0]  commit_len;
      logic              scan_en;
      logic [7:0]        scan_byte;
      logic              clear;
   } cell_ctrl_type;
endpackage

@@ rtl/mksm_key_cell.sv @@
// ----------------------------------------------------------------------------
// mksm_key_cell
// One key slot: holds its key bytes and length and tracks prefix progress.
// ----------------------------------------------------------------------------
module mksm_key_cell import mksm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [SLOT_W-1:0] slot_id,
   input  cell_ctrl_type     ctrl,
   input  logic              match_in,
   output logic              match_out,
   output logic              empty_key
);
   logic [7:0]             key_ff [MAX_KEY_LEN];
   logic [LEN_W-1:0]       len_ff;
   logic                   used_ff;
   logic [MAX_KEY_LEN-1:0] prog_ff, prog_in, prog_base;
   logic                   hit_ff, hit_in;
   logic                   mine;

   assign mine = (ctrl.wr_slot == slot_id);

   always_ff @(posedge clock) begin
      if (ctrl.wr_en && mine) begin
         key_ff[ctrl.wr_pos] <= ctrl.wr_byte;
      end
      if (ctrl.commit && mine) begin
         len_ff <= ctrl.commit_len;
      end
   end

   always_comb begin
      prog_base = ctrl.clear ? '0 : prog_ff;
      prog_in   = prog_base;
      hit_in    = ctrl.clear ? 1'b0 : hit_ff;
      if (ctrl.scan_en && used_ff && len_ff != '0) begin
         for (int j = 0; j < MAX_KEY_LEN; j++) begin
            if (j < int'(len_ff)) begin
               if (j == 0) begin
                  prog_in[j] = (key_ff[j] == ctrl.scan_byte);
               end else begin
                  prog_in[j] = prog_base[j-1] && (key_ff[j] == ctrl.scan_byte);
               end
            end
         end
         if (prog_in[POS_W'(len_ff - LEN_W'(1))]) begin
            hit_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         prog_ff <= '0;
         hit_ff  <= 1'b0;
      end else begin
         if (ctrl.commit && mine) begin
            used_ff <= 1'b1;
         end
         prog_ff <= prog_in;
         hit_ff  <= hit_in;
      end
   end

   assign match_out = match_in | hit_in;
   assign empty_key = used_ff && (len_ff == '0);
endmodule

@@ rtl/multi_key_substring_matcher.sv @@
// ----------------------------------------------------------------------------
// multi_key_substring_matcher
// Stores up to 64 keys and reports whether a streamed line contains any.
// ----------------------------------------------------------------------------
// One word is taken every cycle unless intake is stalled, key or line byte
// alike; a row of key cells advances all prefix progress in parallel, so a
// result is shown in the cycle after the last word of its run. A held result
// stalls intake only while the output register is full and stalled.
module multi_key_substring_matcher import mksm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_operation,
   input  logic [7:0]       req_data_byte,
   input  logic             req_last_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [2:0]       rsp_result_code,
   output logic [6:0]       rsp_stored_count
);
`include "multi_key_substring_matcher_defines.svh"
   logic [CNT_W-1:0] slots_ff, offered_ff;
   logic [LEN_W-1:0] raw_ff, eff_ff;
   logic             zseen_ff, lzero_ff, clear_ff;
   logic             valid_ff;
   logic [2:0]       code_ff;
   logic [6:0]       count_ff;
   logic             fire, is_load, is_scan, any_match, any_empty;
   cell_ctrl_type    ctrl;
   logic [NUM_KEYS:0] chain;
   logic [NUM_KEYS-1:0] empties;
   logic [LEN_W-1:0] raw_in, eff_in;
   logic             zseen_in, room;
   logic [2:0]       code_in;
   logic [CNT_W-1:0] slots_in, offered_in;

   assign req_stall = valid_ff && rsp_stall;
   assign fire      = req_valid && !req_stall;
   assign is_load   = fire && (req_operation == OP_LOAD);
   assign is_scan   = fire && (req_operation == OP_SCAN);
   assign room      = slots_ff < CNT_W'(NUM_KEYS);

   always_comb begin
      raw_in   = raw_ff;
      eff_in   = eff_ff;
      zseen_in = zseen_ff;
      ctrl     = '0;
      ctrl.wr_slot    = SLOT_W'(slots_ff);
      ctrl.wr_pos     = POS_W'(eff_ff);
      ctrl.wr_byte    = req_data_byte;
      ctrl.commit_len = eff_ff;
      ctrl.scan_byte  = req_data_byte;
      ctrl.clear      = clear_ff;
      if (is_load) begin
         if (raw_ff < LEN_W'(MAX_KEY_LEN)) begin
            if (!zseen_ff) begin
               if (req_data_byte == 8'd0) begin
                  zseen_in = 1'b1;
               end else if (room) begin
                  ctrl.wr_en = 1'b1;
                  eff_in = eff_ff + LEN_W'(1);
               end
            end
            raw_in = raw_ff + LEN_W'(1);
         end else begin
            raw_in = LEN_W'(MAX_KEY_LEN + 1);
         end
         ctrl.commit_len = eff_in;
      end
      ctrl.scan_en = is_scan && !lzero_ff && (req_data_byte != 8'd0);
      slots_in   = slots_ff;
      offered_in = offered_ff;
      code_in    = RC_STORED;
      if (is_load && req_last_byte) begin
         if (offered_ff >= CNT_W'(NUM_KEYS)) begin
            code_in = RC_FULL;
         end else begin
            offered_in = offered_ff + CNT_W'(1);
            if (raw_in > LEN_W'(MAX_KEY_LEN)) begin
               code_in = RC_TOO_LONG;
            end else if (room) begin
               ctrl.commit = 1'b1;
               slots_in = slots_ff + CNT_W'(1);
            end
         end
      end
      if (is_scan) begin
         code_in = (any_match || any_empty) ? RC_MATCHED : RC_NO_MATCH;
      end
   end

   // A clear pending from the previous line end is applied before this byte.
   assign chain[0] = 1'b0;
   for (genvar s = 0; s < NUM_KEYS; s++) begin : g_cell
      mksm_key_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .slot_id   (SLOT_W'(s)),
         .ctrl      (ctrl),
         .match_in  (chain[s]),
         .match_out (chain[s+1]),
         .empty_key (empties[s])
      );
   end
   assign any_match = chain[NUM_KEYS];
   assign any_empty = |empties;

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff   <= '0;
         offered_ff <= '0;
         raw_ff     <= '0;
         eff_ff     <= '0;
         zseen_ff   <= 1'b0;
         lzero_ff   <= 1'b0;
         clear_ff   <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         slots_ff   <= slots_in;
         offered_ff <= offered_in;
         clear_ff   <= 1'b0;
         if (is_load) begin
            if (req_last_byte) begin
               raw_ff   <= '0;
               eff_ff   <= '0;
               zseen_ff <= 1'b0;
            end else begin
               raw_ff   <= raw_in;
               eff_ff   <= eff_in;
               zseen_ff <= zseen_in;
            end
         end
         if (is_scan) begin
            if (req_last_byte) begin
               lzero_ff <= 1'b0;
               clear_ff <= 1'b1;
            end else if (req_data_byte == 8'd0) begin
               lzero_ff <= 1'b1;
            end
         end
         if (fire && req_last_byte) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && req_last_byte) begin
         code_ff  <= code_in;
         count_ff <= 7'(slots_in);
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_result_code  = code_ff;
   assign rsp_stored_count = count_ff;

   `MKSM_ASSERT_IMP(a_slots_bound, clock, reset, 1'b1, slots_ff <= CNT_W'(NUM_KEYS), "slots overflow")
   `MKSM_ASSERT_IMP(a_slots_le_off, clock, reset, 1'b1, slots_ff <= offered_ff, "slots exceed offered")
   `MKSM_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_result_code), "result lost")
endmodule

@@ bench/multi_key_substring_matcher_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_key_substring_matcher_checker
// Watches both channels of the matcher, predicts each result from the words
// accepted on the input side and compares it with the result delivered.
// ----------------------------------------------------------------------------
module multi_key_substring_matcher_checker import mksm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic       req_operation,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [2:0] rsp_result_code,
   input  logic [6:0] rsp_stored_count,
   output int         failures,
   output int         pending,
   output int         results_seen
);
   typedef struct packed {
      result_code_type code;
      logic [6:0]      count;
   } answer_type;

   logic [7:0] keys[NUM_KEYS][MAX_KEY_LEN];
   int         key_len[NUM_KEYS];
   int         slots, offered, raw_len, eff_len;
   bit         load_zero, line_zero, line_hit;
   bit         progress[NUM_KEYS][MAX_KEY_LEN];
   answer_type answers[$];

   function automatic answer_type predict_word(logic op, logic [7:0] b, logic last);
      answer_type a;
      bit hit;
      a.code = RC_STORED;
      a.count = '0;
      if (op == OP_LOAD) begin
         if (raw_len < MAX_KEY_LEN) begin
            if (!load_zero) begin
               if (b == 8'd0) load_zero = 1;
               else if (slots < NUM_KEYS) begin
                  keys[slots][eff_len] = b;
                  eff_len++;
               end
            end
            raw_len++;
         end else begin
            raw_len = MAX_KEY_LEN + 1;
         end
         if (last) begin
            if (offered >= NUM_KEYS) a.code = RC_FULL;
            else begin
               offered++;
               if (raw_len > MAX_KEY_LEN) a.code = RC_TOO_LONG;
               else if (slots < NUM_KEYS) begin
                  key_len[slots] = eff_len;
                  slots++;
               end
            end
            raw_len = 0;
            eff_len = 0;
            load_zero = 0;
         end
      end else begin
         if (!line_zero) begin
            if (b == 8'd0) line_zero = 1;
            else begin
               for (int s = 0; s < slots; s++) begin
                  if (key_len[s] == 0) continue;
                  for (int j = key_len[s] - 1; j > 0; j--)
                     progress[s][j] = progress[s][j-1] && keys[s][j] == b;
                  progress[s][0] = keys[s][0] == b;
                  if (progress[s][key_len[s]-1]) line_hit = 1;
               end
            end
         end
         if (last) begin
            hit = line_hit;
            for (int s = 0; s < slots; s++)
               if (key_len[s] == 0) hit = 1;
            a.code = hit ? RC_MATCHED : RC_NO_MATCH;
            progress = '{default: '{default: 0}};
            line_hit = 0;
            line_zero = 0;
         end
      end
      a.count = slots[6:0];
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type p, e;
      if (reset) begin
         slots = 0; offered = 0; raw_len = 0; eff_len = 0;
         load_zero = 0; line_zero = 0; line_hit = 0;
         progress = '{default: '{default: 0}};
         answers.delete();
         failures = 0;
         results_seen = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (answers.size() == 0) begin
               failures++;
               $display("%0t: unexpected result code %0d count %0d", $time,
                        rsp_result_code, rsp_stored_count);
            end else begin
               e = answers.pop_front();
               if (rsp_result_code !== e.code) begin
                  failures++;
                  $display("%0t: result_code expected %0d actual %0d", $time,
                           e.code, rsp_result_code);
               end
               if (rsp_stored_count !== e.count) begin
                  failures++;
                  $display("%0t: stored_count expected %0d actual %0d", $time,
                           e.count, rsp_stored_count);
               end
            end
         end
         if (req_valid && !req_stall) begin
            p = predict_word(req_operation, req_data_byte, req_last_byte);
            if (req_last_byte) answers.push_back(p);
         end
      end
      pending = answers.size();
   end
endmodule

@@ bench/multi_key_substring_matcher_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_key_substring_matcher_test
// Loads keys of every shape, including empty, zero-cut, too long and over the
// table limit, and scans directed and random lines in several idling phases.
// ----------------------------------------------------------------------------
module multi_key_substring_matcher_test;
   import mksm_pkg::*;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_operation;
   logic [7:0] req_data_byte;
   logic       req_last_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [2:0] rsp_result_code;
   logic [6:0] rsp_stored_count;
   int         failures, pending, results_seen;
   int         send_idle, recv_stall, words_sent;
   bit         hold_off;
   logic [7:0] alphabet[4] = '{8'h61, 8'h62, 8'h00, 8'hFF};

   multi_key_substring_matcher uut (.*);
   multi_key_substring_matcher_checker check (.*);

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   initial begin
      #20ms;
      $display("multi_key_substring_matcher regression: fail");
      $finish;
   end

   always @(negedge clock) begin
      if (reset || hold_off) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < recv_stall);
   end

   task automatic send_word(logic op, logic [7:0] b, logic last);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
   endtask

   task automatic send_run(logic op, int len, bit narrow);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         b = narrow ? alphabet[$urandom_range(1) + ($urandom_range(9) == 0 ? 2 : 0)]
                    : 8'($urandom);
         send_word(op, b, i == len - 1);
      end
   endtask

   task automatic send_text(logic op, string s);
      for (int i = 0; i < s.len(); i++) send_word(op, s[i], i == s.len() - 1);
   endtask

   task automatic drain();
      go_idle();
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_LOAD;
      req_data_byte = '0;
      req_last_byte = 1'b0;
      hold_off = 0;
      send_idle = 0;
      recv_stall = 0;
      words_sent = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_text(OP_SCAN, "abc");
      send_text(OP_LOAD, "bc");
      send_text(OP_SCAN, "xabcx");
      send_text(OP_SCAN, "ab");
      send_word(OP_LOAD, 8'hFF, 1'b0);
      send_word(OP_LOAD, 8'h00, 1'b0);
      send_word(OP_LOAD, 8'h01, 1'b1);
      send_word(OP_SCAN, 8'h00, 1'b0);
      send_word(OP_SCAN, 8'hFF, 1'b1);
      send_word(OP_SCAN, 8'hFF, 1'b1);
      send_run(OP_LOAD, MAX_KEY_LEN, 0);
      send_run(OP_LOAD, MAX_KEY_LEN + 1, 0);
      send_run(OP_LOAD, MAX_KEY_LEN + 9, 0);
      send_word(OP_SCAN, 8'h62, 1'b0);
      send_text(OP_LOAD, "cd");
      send_text(OP_SCAN, "cd");
      drain();

      fork
         begin
            hold_off = 1;
            repeat (60) @(negedge clock);
            hold_off = 0;
         end
         begin
            for (int i = 0; i < 6; i++) send_run(OP_SCAN, 2, 1);
            go_idle();
         end
      join
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle = (ph == 1 || ph == 3) ? 63 : 0;
         recv_stall = (ph == 2 || ph == 3) ? 63 : 0;
         if (ph == 3) begin
            send_idle = 10;
            recv_stall = 10;
         end
         for (int n = 0; n < 50; n++) begin
            if ($urandom_range(1) == 0)
               send_run(OP_LOAD, $urandom_range(9) == 0 ? $urandom_range(MAX_KEY_LEN + 3)
                        + 1 : $urandom_range(4) + 1, 1);
            else send_run(OP_SCAN, $urandom_range(7) + 1, $urandom_range(4) != 0);
         end
         drain();
      end

      $display("Sent %0d words, %0d results checked, keys filled past the table limit.",
               words_sent, results_seen);
      if (failures == 0) $display("multi_key_substring_matcher regression: pass");
      else $display("multi_key_substring_matcher regression: fail");
      $finish;
   end
endmodule
